// ----- hdl/pdsc_pkg.sv -----
// ----------------------------------------------------------------------------
// pdsc_pkg: shared types and constants of the packet deframer
// Field widths, status codes, result item layout and queue sizing.
// ----------------------------------------------------------------------------
package pdsc_pkg;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = 9'd511;
  localparam logic [COUNT_W-1:0] HEADER_BYTES = 9'd3;
  localparam logic [COUNT_W-1:0] MIN_PACKET   = 9'd4;

  localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'd170;

  // Default depth of the result queue; it must hold at least two items.
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_TOO_SHORT = 3'd1,
    STATUS_BAD_START = 3'd2,
    STATUS_TRUNCATED = 3'd3,
    STATUS_BAD_SUM   = 3'd4
  } status_t;

  typedef struct packed {
    logic                item_kind;
    logic [BYTE_W-1:0]   payload_data;
    logic [STATUS_W-1:0] parse_status;
    logic [BYTE_W-1:0]   command_code;
    logic [BYTE_W-1:0]   payload_count;
  } result_t;

  // What the parser hands to the result queue for one accepted byte.
  typedef struct packed {
    logic    payload_push;
    logic    status_push;
    result_t payload_item;
    result_t status_item;
  } push_t;

endpackage

// ----- hdl/pdsc_byte_if.sv -----
// ----------------------------------------------------------------------------
// pdsc_byte_if: input byte channel
// Valid/ready channel carrying one received byte and its end-of-buffer flag.
// ----------------------------------------------------------------------------
interface pdsc_byte_if import pdsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

// ----- hdl/pdsc_result_if.sv -----
// ----------------------------------------------------------------------------
// pdsc_result_if: result item channel
// Valid/ready channel carrying payload bytes and final buffer status.
// ----------------------------------------------------------------------------
interface pdsc_result_if import pdsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                item_kind;
  logic [BYTE_W-1:0]   payload_data;
  logic [STATUS_W-1:0] parse_status;
  logic [BYTE_W-1:0]   command_code;
  logic [BYTE_W-1:0]   payload_count;

  modport source (output valid, output item_kind, output payload_data,
                  output parse_status, output command_code, output payload_count,
                  input ready);
  modport sink   (input valid, input item_kind, input payload_data,
                  input parse_status, input command_code, input payload_count,
                  output ready);
endinterface

// ----- hdl/packet_deframer_sum_checksum_core.sv -----
// ----------------------------------------------------------------------------
// packet_deframer_sum_checksum_core: start-byte/length packet deframer
// Passes payload bytes on and reports a final status with an 8-bit sum check.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                                  Moves per transfer
//   rx       in         rx_byte, end_of_buffer                   one buffer byte
//   tx       out        item_kind, payload_data, parse_status,   one result item
//                       command_code, payload_count
//   cfg      in         cfg_data (start_marker)                  one register write
//
// A byte is taken in every cycle while the result queue has room for two items,
// so the sustained rate is one byte per clock; the parser update is a single
// 8-bit add and compare per byte. Results are held in and presented from a
// registered queue. Only a final byte that also carries payload
// yields two results; the queue absorbs the second one without a stall when
// the output side keeps up. Reset (rst, synchronous) empties the queue, clears
// the buffer state and sets start_marker to 170. A stalled output only holds
// off input once fewer than two queue entries are free.
//
module packet_deframer_sum_checksum_core import pdsc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [BYTE_W-1:0]    cfg_data,
  pdsc_byte_if.sink            rx,
  pdsc_result_if.source        tx
);

  push_t   push;
  logic    room_for_two;
  logic    in_fire;
  result_t out_item;

  // Input is accepted whenever the queue can take the worst case of two items.
  assign rx.ready = room_for_two;
  assign in_fire  = rx.valid && room_for_two;

  // The parser holds all per-buffer state and decides, for each byte, whether
  // a payload item, a status item or both are produced.
  pdsc_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_fire       (in_fire),
    .rx_byte       (rx.rx_byte),
    .end_of_buffer (rx.end_of_buffer),
    .push          (push)
  );

  // The queue registers results and decouples the output handshake.
  pdsc_result_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room_for_two (room_for_two),
    .out_valid    (tx.valid),
    .out_item     (out_item),
    .out_ready    (tx.ready)
  );

  assign tx.item_kind     = out_item.item_kind;
  assign tx.payload_data  = out_item.payload_data;
  assign tx.parse_status  = out_item.parse_status;
  assign tx.command_code  = out_item.command_code;
  assign tx.payload_count = out_item.payload_count;

endmodule

// ----- hdl/pdsc_parser.sv -----
// ----------------------------------------------------------------------------
// pdsc_parser: per-byte packet parsing state
// Tracks position, header fields and running sum; builds result items.
// ----------------------------------------------------------------------------
module pdsc_parser import pdsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_data,
  input  logic              in_fire,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              end_of_buffer,
  output push_t             push
);

  logic [BYTE_W-1:0]  start_marker;
  logic [COUNT_W-1:0] bytes_seen;
  logic               start_matched;
  logic [BYTE_W-1:0]  held_command;
  logic [BYTE_W-1:0]  held_length;
  logic [BYTE_W-1:0]  running_sum;
  logic               sum_matched;

  logic [COUNT_W-1:0] bytes_seen_next;
  logic               start_matched_next;
  logic [BYTE_W-1:0]  held_command_next;
  logic [BYTE_W-1:0]  held_length_next;
  logic [BYTE_W-1:0]  running_sum_next;
  logic               sum_matched_next;

  logic [COUNT_W-1:0] check_pos;
  logic [COUNT_W-1:0] full_len;
  logic               is_payload;
  status_t            status;

  assign check_pos = HEADER_BYTES + {1'b0, held_length};

  always_comb begin
    start_matched_next = start_matched;
    held_command_next  = held_command;
    held_length_next   = held_length;
    running_sum_next   = running_sum;
    sum_matched_next   = sum_matched;
    is_payload         = 1'b0;
    if (bytes_seen == '0) begin
      start_matched_next = (rx_byte == start_marker);
    end else if (bytes_seen == 9'd1) begin
      held_command_next = rx_byte;
      running_sum_next  = rx_byte;
    end else if (bytes_seen == 9'd2) begin
      held_length_next = rx_byte;
      running_sum_next = running_sum + rx_byte;
    end else if (bytes_seen < check_pos) begin
      running_sum_next = running_sum + rx_byte;
      is_payload       = 1'b1;
    end else if (bytes_seen == check_pos) begin
      sum_matched_next = (rx_byte == running_sum);
    end
    bytes_seen_next = (bytes_seen < COUNT_MAX) ? bytes_seen + 9'd1 : bytes_seen;
  end

  assign full_len = {1'b0, held_length_next} + MIN_PACKET;

  always_comb begin
    if (bytes_seen_next < MIN_PACKET) begin
      status = STATUS_TOO_SHORT;
    end else if (!start_matched_next) begin
      status = STATUS_BAD_START;
    end else if (bytes_seen_next < full_len) begin
      status = STATUS_TRUNCATED;
    end else if (!sum_matched_next) begin
      status = STATUS_BAD_SUM;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    push.payload_push               = in_fire && is_payload;
    push.status_push                = in_fire && end_of_buffer;
    push.payload_item.item_kind     = KIND_PAYLOAD;
    push.payload_item.payload_data  = rx_byte;
    push.payload_item.parse_status  = STATUS_OK;
    push.payload_item.command_code  = '0;
    push.payload_item.payload_count = '0;
    push.status_item.item_kind      = KIND_STATUS;
    push.status_item.payload_data   = '0;
    push.status_item.parse_status   = status;
    push.status_item.command_code   = held_command_next;
    push.status_item.payload_count  = held_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RESET;
    end else if (cfg_we) begin
      start_marker <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      start_matched <= 1'b0;
      held_command  <= '0;
      held_length   <= '0;
      running_sum   <= '0;
      sum_matched   <= 1'b0;
    end else if (in_fire) begin
      if (end_of_buffer) begin
        // The status closes the buffer; start fresh for the next one.
        bytes_seen    <= '0;
        start_matched <= 1'b0;
        held_command  <= '0;
        held_length   <= '0;
        running_sum   <= '0;
        sum_matched   <= 1'b0;
      end else begin
        bytes_seen    <= bytes_seen_next;
        start_matched <= start_matched_next;
        held_command  <= held_command_next;
        held_length   <= held_length_next;
        running_sum   <= running_sum_next;
        sum_matched   <= sum_matched_next;
      end
    end
  end

endmodule

// ----- hdl/pdsc_result_queue.sv -----
// ----------------------------------------------------------------------------
// pdsc_result_queue: registered result queue
// Takes up to two items per cycle and presents one registered item per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module pdsc_result_queue import pdsc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room_for_two,
  output logic    out_valid,
  output result_t out_item,
  input  logic    out_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(DEPTH - 2);

  result_t          mem [DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;

  logic [PTR_W-1:0] wr_ptr_plus1;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_plus1;
  logic [CNT_W-1:0] count_next;
  logic             pop;
  logic [1:0]       n_push;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign wr_ptr_plus1 = ptr_inc(wr_ptr);
  assign rd_ptr_plus1 = ptr_inc(rd_ptr);
  assign n_push       = {1'b0, push.payload_push} + {1'b0, push.status_push};
  assign pop          = out_valid && out_ready;
  assign room_for_two = (count <= LIMIT);
  assign out_valid    = (count != '0);
  assign out_item     = mem[rd_ptr];

  always_comb begin
    case (n_push)
      2'd1:    wr_ptr_next = wr_ptr_plus1;
      2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus1);
      default: wr_ptr_next = wr_ptr;
    endcase
    count_next = count + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.payload_push) begin
      mem[wr_ptr] <= push.payload_item;
      if (push.status_push) begin
        mem[wr_ptr_plus1] <= push.status_item;
      end
    end else if (push.status_push) begin
      mem[wr_ptr] <= push.status_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr_plus1;
      end
    end
  end

endmodule
